FILE: rtl/core/button_gesture_tracker_core_defines.svh
`ifndef BUTTON_GESTURE_TRACKER_CORE_DEFINES_SVH
`define BUTTON_GESTURE_TRACKER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BGT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("button tracker assertion failed");
`define BGT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("button tracker forbidden condition seen");
`else
`define BGT_ASSERT(lbl, clk, rst_n, prop)
`define BGT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/bgt_pkg.sv
package bgt_pkg;

    localparam int NUM_LANES       = 3;
    localparam int SLEEP_DELAY_DEF = 5000;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 64;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_DRAIN  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_STATE  = 2'd1,
        KIND_REPEAT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2,
        ST_REPEAT   = 2'd3
    } t_press;

    typedef enum logic [1:0] {
        REG_MODE_FLAGS      = 2'd0,
        REG_UPDATE_INTERVAL = 2'd1,
        REG_REPEAT_TIMEOUT  = 2'd2,
        REG_REPEAT_COUNT    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        hold_en;
        logic        rep_en;
        logic [15:0] interval;
        logic [15:0] timeout;
        logic [7:0]  count;
    } t_lane_cfg;

    typedef struct packed {
        t_req        req;
        logic        level;
        logic [31:0] now;
        logic        accept;
        logic        clear;
    } t_lane_req;

    typedef struct packed {
        t_press      hold_state;
        logic        state_pending;
        logic        repeat_pending;
        logic [31:0] duration;
        logic        tick_act;
        logic        tick_held;
    } t_lane_out;

    typedef struct packed {
        logic        drain;
        logic        act;
        logic        fire;
        logic [31:0] sleep;
    } t_beat_info;

endpackage

FILE: rtl/core/bgt_lane.sv
module bgt_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bgt_pkg::t_lane_cfg  i_cfg,
    input  bgt_pkg::t_lane_req  i_req,
    output bgt_pkg::t_lane_out  o_lane
);

    bgt_pkg::t_press r_hold_state, n_hold_state;
    logic [31:0]     r_hold_start, n_hold_start;
    logic [31:0]     r_next_update, n_next_update;
    logic [31:0]     r_repeat_deadline, n_repeat_deadline;
    logic [7:0]      r_press_count, n_press_count;
    logic            r_state_pending, n_state_pending;
    logic            r_repeat_pending, n_repeat_pending;

    logic            held_hit;
    logic            count_hit;
    logic            window_hit;
    logic            tick_act;

    always_comb begin
        held_hit   = (r_next_update != 32'd0) && (i_req.now >= r_next_update)
                     && (r_hold_state != bgt_pkg::ST_RELEASED);
        count_hit  = (i_cfg.count != 8'd0) && (r_press_count >= i_cfg.count);
        window_hit = (r_repeat_deadline != 32'd0) && (i_req.now >= r_repeat_deadline);
    end

    always_comb begin
        n_hold_state      = r_hold_state;
        n_hold_start      = r_hold_start;
        n_next_update     = r_next_update;
        n_repeat_deadline = r_repeat_deadline;
        n_press_count     = r_press_count;
        n_state_pending   = r_state_pending;
        n_repeat_pending  = r_repeat_pending;
        tick_act          = 1'b0;
        if (held_hit) begin
            tick_act = 1'b1;
        end
        if (count_hit) begin
            tick_act = 1'b1;
        end
        if (window_hit && (held_hit || count_hit
                           || (r_hold_state != bgt_pkg::ST_RELEASED))) begin
            tick_act = 1'b1;
        end
        if (i_req.clear) begin
            n_hold_state      = bgt_pkg::ST_RELEASED;
            n_hold_start      = 32'd0;
            n_next_update     = 32'd0;
            n_repeat_deadline = 32'd0;
            n_press_count     = 8'd0;
            n_state_pending   = 1'b0;
            n_repeat_pending  = 1'b0;
        end else if (i_req.accept) begin
            case (i_req.req)
                bgt_pkg::REQ_SAMPLE: begin
                    if (i_req.level) begin
                        if (r_hold_state == bgt_pkg::ST_RELEASED) begin
                            n_hold_state    = bgt_pkg::ST_PRESSED;
                            n_state_pending = 1'b1;
                            if (i_cfg.hold_en) begin
                                n_hold_start  = i_req.now;
                                n_next_update = i_req.now + {16'd0, i_cfg.interval};
                            end
                            if (i_cfg.rep_en) begin
                                n_press_count     = r_press_count + 8'd1;
                                n_state_pending   = 1'b0;
                                n_repeat_deadline = i_req.now + {16'd0, i_cfg.timeout};
                            end
                        end
                    end else if (r_hold_state != bgt_pkg::ST_RELEASED) begin
                        n_state_pending = 1'b1;
                        n_hold_start    = 32'd0;
                        n_next_update   = 32'd0;
                        n_hold_state    = bgt_pkg::ST_RELEASED;
                    end
                end
                bgt_pkg::REQ_TICK: begin
                    if (held_hit) begin
                        n_state_pending = 1'b1;
                        n_hold_state    = bgt_pkg::ST_HELD;
                        n_next_update   = i_req.now + {16'd0, i_cfg.interval};
                    end
                    if (count_hit) begin
                        n_repeat_pending = 1'b1;
                        n_hold_state     = bgt_pkg::ST_REPEAT;
                        n_press_count    = 8'd0;
                    end
                    if (window_hit) begin
                        n_press_count = 8'd0;
                        if (n_hold_state != bgt_pkg::ST_RELEASED) begin
                            n_state_pending = 1'b1;
                        end
                    end
                end
                bgt_pkg::REQ_DRAIN: begin
                    n_state_pending  = 1'b0;
                    n_repeat_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_state      <= bgt_pkg::ST_RELEASED;
            r_hold_start      <= 32'd0;
            r_next_update     <= 32'd0;
            r_repeat_deadline <= 32'd0;
            r_press_count     <= 8'd0;
            r_state_pending   <= 1'b0;
            r_repeat_pending  <= 1'b0;
        end else begin
            r_hold_state      <= n_hold_state;
            r_hold_start      <= n_hold_start;
            r_next_update     <= n_next_update;
            r_repeat_deadline <= n_repeat_deadline;
            r_press_count     <= n_press_count;
            r_state_pending   <= n_state_pending;
            r_repeat_pending  <= n_repeat_pending;
        end
    end

    always_comb begin
        o_lane.hold_state     = r_hold_state;
        o_lane.state_pending  = r_state_pending;
        o_lane.repeat_pending = r_repeat_pending;
        o_lane.duration       = i_req.now - r_hold_start;
        o_lane.tick_act       = tick_act;
        o_lane.tick_held      = held_hit;
    end

endmodule

FILE: rtl/core/bgt_merge.sv
module bgt_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bgt_pkg::t_beat_info i_info,
    input  bgt_pkg::t_lane_out  i_lanes [bgt_pkg::NUM_LANES],
    input  logic                i_stall,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [1:0]          o_button_id,
    output logic [1:0]          o_press_state,
    output logic [31:0]         o_held_duration,
    output logic                o_fire_down,
    output logic                o_activity,
    output logic [31:0]         o_sleep_deadline,
    output logic                o_last
);

    localparam int NBEATS = 2 * bgt_pkg::NUM_LANES;

    logic [NBEATS-1:0]   r_mask, n_mask;
    logic                r_stat, n_stat;
    logic                r_act;
    logic                r_fire;
    logic [31:0]         r_sleep;
    bgt_pkg::t_press     r_st  [bgt_pkg::NUM_LANES];
    logic [31:0]         r_dur [bgt_pkg::NUM_LANES];

    logic [NBEATS-1:0]   load_mask;
    logic [2:0]          sel;
    logic [1:0]          sel_lane;
    logic                sel_rep;
    logic                out_acc;

    always_comb begin
        load_mask = '0;
        for (int k = 0; k < bgt_pkg::NUM_LANES; k++) begin
            load_mask[2*k]   = i_info.drain & i_lanes[k].state_pending;
            load_mask[2*k+1] = i_info.drain & i_lanes[k].repeat_pending;
        end
    end

    always_comb begin
        sel = 3'd0;
        for (int j = NBEATS - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                sel = 3'(j);
            end
        end
        sel_lane = sel[2:1];
        sel_rep  = sel[0];
    end

    always_comb begin
        o_valid          = r_stat | (|r_mask);
        o_last           = r_stat | ((r_mask & (r_mask - NBEATS'(1))) == '0);
        o_fire_down      = r_fire;
        o_activity       = r_act;
        o_sleep_deadline = r_sleep;
        if (r_stat) begin
            o_kind          = bgt_pkg::KIND_STATUS;
            o_button_id     = 2'd0;
            o_press_state   = bgt_pkg::ST_RELEASED;
            o_held_duration = 32'd0;
        end else if (sel_rep) begin
            o_kind          = bgt_pkg::KIND_REPEAT;
            o_button_id     = sel_lane;
            o_press_state   = bgt_pkg::ST_REPEAT;
            o_held_duration = 32'd0;
        end else begin
            o_kind          = bgt_pkg::KIND_STATE;
            o_button_id     = sel_lane;
            o_press_state   = r_st[sel_lane];
            o_held_duration = r_dur[sel_lane];
        end
    end

    assign out_acc = o_valid & ~i_stall;

    always_comb begin
        n_mask = r_mask;
        n_stat = r_stat;
        if (i_load) begin
            n_mask = load_mask;
            n_stat = (load_mask == '0);
        end else if (out_acc) begin
            n_mask = r_mask & (r_mask - NBEATS'(1));
            n_stat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_stat <= 1'b0;
        end else begin
            r_mask <= n_mask;
            r_stat <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_act   <= i_info.act;
            r_fire  <= i_info.fire;
            r_sleep <= i_info.sleep;
            for (int k = 0; k < bgt_pkg::NUM_LANES; k++) begin
                r_st[k]  <= i_lanes[k].hold_state;
                r_dur[k] <= i_lanes[k].duration;
            end
        end
    end

endmodule

FILE: rtl/core/button_gesture_tracker_core.sv
// Latency: the first result beat of an accepted item is valid in the next cycle.
// Throughput: one item per cycle while each item yields one result and the output
// is not stalled; a drain with n pending callbacks holds the output for n beats, one per callback.
// Reset (synchronous, active low) clears the registers and all lane state at once;
// a register write also clears all lane state and the shared flags.
`include "button_gesture_tracker_core_defines.svh"

module button_gesture_tracker_core #(
    parameter int SLEEP_DELAY = bgt_pkg::SLEEP_DELAY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bgt_pkg::ADDR_W-1:0] paddr,
    input  logic [bgt_pkg::DATA_W-1:0] pwdata,
    output logic [bgt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_req_type,
    input  logic [2:0]                 i_button_bits,
    input  logic [31:0]                i_now,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_kind,
    output logic [1:0]                 o_button_id,
    output logic [1:0]                 o_press_state,
    output logic [31:0]                o_held_duration,
    output logic                       o_fire_down,
    output logic                       o_activity,
    output logic [31:0]                o_sleep_deadline,
    output logic                       o_last
);

    logic [5:0]  r_mode_flags;
    logic [47:0] r_update_intervals;
    logic [47:0] r_repeat_timeouts;
    logic [23:0] r_repeat_counts;
    logic [31:0] r_idle_deadline, n_idle_deadline;
    logic        r_fire_level, n_fire_level;

    logic                cfg_wr;
    bgt_pkg::t_reg_idx   reg_idx;
    bgt_pkg::t_req       req;
    logic                in_acc;
    logic                act;
    logic                any_held;
    logic                any_tick_act;
    logic                any_pending;
    bgt_pkg::t_lane_cfg  lane_cfg [bgt_pkg::NUM_LANES];
    bgt_pkg::t_lane_req  lane_req [bgt_pkg::NUM_LANES];
    bgt_pkg::t_lane_out  lane_out [bgt_pkg::NUM_LANES];
    bgt_pkg::t_beat_info info;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = bgt_pkg::t_reg_idx'(paddr[4:3]);
    assign req     = bgt_pkg::t_req'(i_req_type);
    assign in_acc  = i_valid & ~o_stall;
    assign o_stall = o_valid & ~(~i_stall & o_last);

    always_comb begin
        case (reg_idx)
            bgt_pkg::REG_MODE_FLAGS:      prdata = {58'd0, r_mode_flags};
            bgt_pkg::REG_UPDATE_INTERVAL: prdata = {16'd0, r_update_intervals};
            bgt_pkg::REG_REPEAT_TIMEOUT:  prdata = {16'd0, r_repeat_timeouts};
            bgt_pkg::REG_REPEAT_COUNT:    prdata = {40'd0, r_repeat_counts};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_flags       <= 6'd0;
            r_update_intervals <= 48'd0;
            r_repeat_timeouts  <= 48'd0;
            r_repeat_counts    <= 24'd0;
        end else if (cfg_wr) begin
            case (reg_idx)
                bgt_pkg::REG_MODE_FLAGS:      r_mode_flags       <= pwdata[5:0];
                bgt_pkg::REG_UPDATE_INTERVAL: r_update_intervals <= pwdata[47:0];
                bgt_pkg::REG_REPEAT_TIMEOUT:  r_repeat_timeouts  <= pwdata[47:0];
                bgt_pkg::REG_REPEAT_COUNT:    r_repeat_counts    <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < bgt_pkg::NUM_LANES; g++) begin : g_lane
        always_comb begin
            lane_cfg[g].hold_en  = r_mode_flags[2*g];
            lane_cfg[g].rep_en   = r_mode_flags[2*g+1];
            lane_cfg[g].interval = r_update_intervals[16*g +: 16];
            lane_cfg[g].timeout  = r_repeat_timeouts[16*g +: 16];
            lane_cfg[g].count    = r_repeat_counts[8*g +: 8];
            lane_req[g].req      = req;
            lane_req[g].level    = i_button_bits[g];
            lane_req[g].now      = i_now;
            lane_req[g].accept   = in_acc;
            lane_req[g].clear    = cfg_wr;
        end

        bgt_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (lane_cfg[g]),
            .i_req   (lane_req[g]),
            .o_lane  (lane_out[g])
        );
    end

    always_comb begin
        any_held     = 1'b0;
        any_tick_act = 1'b0;
        any_pending  = 1'b0;
        for (int k = 0; k < bgt_pkg::NUM_LANES; k++) begin
            any_held     = any_held | lane_out[k].tick_held;
            any_tick_act = any_tick_act | lane_out[k].tick_act;
            any_pending  = any_pending | lane_out[k].state_pending
                           | lane_out[k].repeat_pending;
        end
    end

    always_comb begin
        n_idle_deadline = r_idle_deadline;
        n_fire_level    = r_fire_level;
        act             = 1'b0;
        if (cfg_wr) begin
            n_idle_deadline = 32'd0;
            n_fire_level    = 1'b0;
        end else if (in_acc) begin
            case (req)
                bgt_pkg::REQ_SAMPLE: begin
                    act             = 1'b1;
                    n_idle_deadline = i_now + 32'(SLEEP_DELAY);
                    if (i_button_bits[0]) begin
                        n_fire_level = 1'b1;
                    end else if (lane_out[0].hold_state != bgt_pkg::ST_RELEASED) begin
                        n_fire_level = 1'b0;
                    end
                end
                bgt_pkg::REQ_TICK: begin
                    act = any_tick_act;
                    if (any_held) begin
                        n_idle_deadline = i_now + 32'(SLEEP_DELAY);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_deadline <= 32'd0;
            r_fire_level    <= 1'b0;
        end else begin
            r_idle_deadline <= n_idle_deadline;
            r_fire_level    <= n_fire_level;
        end
    end

    always_comb begin
        info.drain = (req == bgt_pkg::REQ_DRAIN);
        info.act   = act;
        info.fire  = n_fire_level;
        info.sleep = n_idle_deadline;
    end

    bgt_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (in_acc),
        .i_info           (info),
        .i_lanes          (lane_out),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_button_id      (o_button_id),
        .o_press_state    (o_press_state),
        .o_held_duration  (o_held_duration),
        .o_fire_down      (o_fire_down),
        .o_activity       (o_activity),
        .o_sleep_deadline (o_sleep_deadline),
        .o_last           (o_last)
    );

    // A new beat may only enter when the final beat of the previous item leaves.
    `BGT_ASSERT(a_accept_frees_output, i_clk, i_rst_n, in_acc |-> (!o_valid || (!i_stall && o_last)))
    `BGT_ASSERT(a_result_follows, i_clk, i_rst_n, in_acc |=> o_valid)
    `BGT_ASSERT_NEVER(a_status_is_last, i_clk, i_rst_n, o_valid && (o_kind == bgt_pkg::KIND_STATUS) && !o_last)
    `BGT_ASSERT(a_drain_clears, i_clk, i_rst_n, (in_acc && (req == bgt_pkg::REQ_DRAIN)) |=> !any_pending)

endmodule
